// ===== hdl/mbt_pkg.sv =====
// ----------------------------------------------------------------------------
// mbt_pkg
// Shared widths, register indexes, Q4.28 constants and the saturation helper
// for the escape-time unit.
// ----------------------------------------------------------------------------
package mbt_pkg;

    localparam int DATA_W    = 32;   // Q4.28 word
    localparam int PROD_W    = 64;   // full product of two words
    localparam int SAT_W     = 66;   // headroom for exact sums before saturation
    localparam int FRAC_BITS = 28;
    localparam int PIX_W     = 10;
    localparam int COUNT_W   = 9;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REAL_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REAL_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAG_MAX = 2'd2;

    // reset values: -3.0, +3.0, +2.0
    localparam logic signed [DATA_W-1:0] REAL_MIN_RST = 32'shD000_0000;
    localparam logic signed [DATA_W-1:0] REAL_MAX_RST = 32'sh3000_0000;
    localparam logic signed [DATA_W-1:0] IMAG_MAX_RST = 32'sh2000_0000;

    // 4.0 in Q8.56
    localparam logic [PROD_W-1:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000;

    localparam logic signed [SAT_W-1:0] SAT_HI = 66'sh0_7FFF_FFFF;
    localparam logic signed [SAT_W-1:0] SAT_LO = -66'sh0_8000_0000;

    // clamp an exact wide value to a signed Q4.28 word
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[DATA_W-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[DATA_W-1:0];
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

// ===== hdl/mandelbrot_escape_time.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Maps a pixel to a point c and counts iterations of z = z*z + c until
// |z| > 2 or the count reaches MAX_ITER, in signed Q4.28 fixed point.
// ----------------------------------------------------------------------------
// Sequence: setup states S_STEP, S_CRE, S_CIM and S_INIT, then per iteration
//   S_RR, S_II, S_RI and S_UPD on the one shared multiplier; done pulses when
//   S_UPD sees an escape or the count reaches MAX_ITER.
// Throughput: one pixel at a time; busy stays high until the done beat.
// The receiver cannot stall: done is a one-cycle strobe.
// Reset (rst_n low, asynchronous): idle, no result pending, edge registers
//   back to -3.0, +3.0 and +2.0.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time #(
    parameter int IMAGE_WIDTH = 1024,
    parameter int MAX_ITER    = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // pixel command channel
    input  logic                                start,
    output logic                                busy,
    input  logic [mbt_pkg::PIX_W-1:0]           pixel_x,
    input  logic [mbt_pkg::PIX_W-1:0]           pixel_y,

    // result strobe
    output logic                                done,
    output logic [mbt_pkg::PIX_W-1:0]           out_x,
    output logic [mbt_pkg::PIX_W-1:0]           out_y,
    output logic [mbt_pkg::COUNT_W-1:0]         iteration_count,

    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mbt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mbt_pkg::DATA_W-1:0]          cfg_data
);

    localparam int DW     = mbt_pkg::DATA_W;
    localparam int PW     = mbt_pkg::PROD_W;
    localparam int SW     = mbt_pkg::SAT_W;
    localparam int CW_OUT = mbt_pkg::COUNT_W;
    // the step is (real_max - real_min) / IMAGE_WIDTH, a right shift by floor(log2)
    localparam int WSHIFT = $clog2(IMAGE_WIDTH + 1) - 1;
    localparam int CNT_W  = $clog2(MAX_ITER + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_ITER);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_STEP,   // form the pixel step
        S_CRE,    // issue pixel_x * step
        S_CIM,    // take c.re, issue pixel_y * step
        S_INIT,   // take c.im, clear z
        S_RR,     // issue re*re
        S_II,     // hold re^2, issue im*im
        S_RI,     // escape test and re^2-im^2, issue re*im
        S_UPD     // write back z or finish
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic signed [DW-1:0] real_min_reg, real_max_reg, imag_max_reg;

    // payload registers, no reset
    logic [mbt_pkg::PIX_W-1:0] px_reg, px_next;
    logic [mbt_pkg::PIX_W-1:0] py_reg, py_next;
    logic signed [DW-1:0] step_reg, step_next;
    logic signed [DW-1:0] cre_reg, cre_next;
    logic signed [DW-1:0] cim_reg, cim_next;
    logic signed [DW-1:0] zr_reg, zr_next;
    logic signed [DW-1:0] zi_reg, zi_next;
    logic signed [PW-1:0] rr_reg, rr_next;
    logic signed [PW-1:0] diff_reg, diff_next;
    logic                 esc_reg, esc_next;

    // shared multiplier
    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;

    logic signed [DW:0]   edge_span;
    logic [PW-1:0]        mag_sum;
    logic [CNT_W-1:0]     cnt_inc;
    logic [CNT_W+CW_OUT-1:0] cnt_ext;

    mbt_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign edge_span = (DW + 1)'(real_max_reg) - (DW + 1)'(real_min_reg);
    assign mag_sum   = $unsigned(rr_reg) + $unsigned(prod);
    assign cnt_inc   = cnt_reg + CNT_ONE;

    // operand select for the multiplier: the product is registered and lands in the next cycle
    always_comb
    begin
        mul_a = zr_reg;
        mul_b = zr_reg;
        case (state_reg)
            S_CRE:
            begin
                mul_a = $signed(DW'(px_reg));
                mul_b = step_reg;
            end
            S_CIM:
            begin
                mul_a = $signed(DW'(py_reg));
                mul_b = step_reg;
            end
            S_II:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            S_RI:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
            default:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
        endcase
    end

    // sequencer and datapath next values
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        step_next  = step_reg;
        cre_next   = cre_reg;
        cim_next   = cim_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        rr_next    = rr_reg;
        diff_next  = diff_reg;
        esc_next   = esc_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    px_next    = pixel_x;
                    py_next    = pixel_y;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                step_next  = mbt_pkg::sat32(SW'(edge_span >>> WSHIFT));
                state_next = S_CRE;
            end
            S_CRE:
            begin
                state_next = S_CIM;
            end
            S_CIM:
            begin
                cre_next   = mbt_pkg::sat32(SW'(real_min_reg) + SW'(prod));
                state_next = S_INIT;
            end
            S_INIT:
            begin
                cim_next = mbt_pkg::sat32(SW'(imag_max_reg) - SW'(prod));
                zr_next  = '0;
                zi_next  = '0;
                cnt_next = CNT_ONE;
                if (CNT_ONE < CNT_LIMIT)
                    state_next = S_RR;
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RR:
            begin
                state_next = S_II;
            end
            S_II:
            begin
                rr_next    = prod;
                state_next = S_RI;
            end
            S_RI:
            begin
                esc_next   = (mag_sum > mbt_pkg::ESCAPE_LIMIT);
                diff_next  = rr_reg - prod;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (esc_reg)
                begin
                    // escaped: report the count as it stands
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    zr_next  = mbt_pkg::sat32(SW'(diff_reg >>> mbt_pkg::FRAC_BITS)
                                              + SW'(cre_reg));
                    zi_next  = mbt_pkg::sat32(SW'(prod >>> (mbt_pkg::FRAC_BITS - 1))
                                              + SW'(cim_reg));
                    cnt_next = cnt_inc;
                    if (cnt_inc < CNT_LIMIT)
                        state_next = S_RR;
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, count and the done strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= CNT_ONE;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    // edge registers: one beat per accepted write, unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_min_reg <= mbt_pkg::REAL_MIN_RST;
            real_max_reg <= mbt_pkg::REAL_MAX_RST;
            imag_max_reg <= mbt_pkg::IMAG_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mbt_pkg::CFG_REAL_MIN: real_min_reg <= $signed(cfg_data);
                mbt_pkg::CFG_REAL_MAX: real_max_reg <= $signed(cfg_data);
                mbt_pkg::CFG_IMAG_MAX: imag_max_reg <= $signed(cfg_data);
                default:               ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        step_reg <= step_next;
        cre_reg  <= cre_next;
        cim_reg  <= cim_next;
        zr_reg   <= zr_next;
        zi_reg   <= zi_next;
        rr_reg   <= rr_next;
        diff_reg <= diff_next;
        esc_reg  <= esc_next;
    end

    // count goes out masked to the field width
    assign cnt_ext         = {{CW_OUT{1'b0}}, cnt_reg};
    assign iteration_count = cnt_ext[CW_OUT-1:0];

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign out_x     = px_reg;
    assign out_y     = py_reg;
    assign cfg_ready = 1'b1;

endmodule

// ===== hdl/mbt_mul.sv =====
// ----------------------------------------------------------------------------
// mbt_mul
// Shared signed 32x32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module mbt_mul (
    input  logic                                 clk,
    input  logic signed [mbt_pkg::DATA_W-1:0]    op_a,
    input  logic signed [mbt_pkg::DATA_W-1:0]    op_b,
    output logic signed [mbt_pkg::PROD_W-1:0]    prod
);

    logic signed [mbt_pkg::PROD_W-1:0] prod_reg;
    logic signed [mbt_pkg::PROD_W-1:0] prod_next;

    assign prod_next = mbt_pkg::PROD_W'(op_a) * mbt_pkg::PROD_W'(op_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/mbt_checker.sv =====
// ----------------------------------------------------------------------------
// mbt_checker
// Port-level checks on the command and result timing of the escape-time unit.
// ----------------------------------------------------------------------------
module mbt_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // an accepted command keeps the unit busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // the result beat comes with the unit already free
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // busy drops only together with a result beat
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // the strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

endmodule

bind mandelbrot_escape_time mbt_checker u_mbt_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
